// File: design/km_pkg.sv
// Shared types and constants for the k-means fitting block.
// Holds item field widths, command and register codes, and the
// command/status structs exchanged by the controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package km_pkg;

    // Fixed widths of the channel and configuration fields.
    localparam int CMD_W      = 3;
    localparam int ROW_W      = 10;
    localparam int FEAT_W     = 6;
    localparam int ELEM_W     = 16;
    localparam int CIDX_W     = 4;
    localparam int HVAL_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CLU_W      = 5;
    localparam int FCNT_W     = 7;
    localparam int SCNT_W     = 11;
    localparam int ITER_W     = 8;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_LD_HEAD   = 3'd0,
        CMD_LD_SAMPLE = 3'd1,
        CMD_FIT       = 3'd2,
        CMD_LD_QUERY  = 3'd3,
        CMD_NEAREST   = 3'd4,
        CMD_RD_ASG    = 3'd5,
        CMD_RD_HEAD   = 3'd6
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLUSTERS = 3'd0,
        REG_FEATURES = 3'd1,
        REG_SAMPLES  = 3'd2,
        REG_ITERS    = 3'd3,
        REG_MODE     = 3'd4
    } t_reg;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_HEAD_LD,
        OP_SAMP_LD,
        OP_QUERY_LD,
        OP_ASG_RD,
        OP_HEAD_RD,
        OP_DIST_RD,
        OP_DIST_DF,
        OP_DIST_AC,
        OP_DIST_CMP,
        OP_ASG_WR,
        OP_SUM_CLR,
        OP_ACC_RD,
        OP_ACC_WR,
        OP_SUM_RD,
        OP_DIV_START,
        OP_HEAD_WR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   first;
        logic   last;
        logic   use_query;
        logic   mode;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic cnt_zero;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: design/km_chan_if.sv
// Channel interfaces for the k-means block: command items in, results out.
// Depends on km_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface km_in_if;
    import km_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [ROW_W-1:0]         row_index;
    logic [FEAT_W-1:0]        feature_index;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, command, row_index, feature_index, element_value,
                    input ready);
    modport sink   (input valid, command, row_index, feature_index, element_value,
                    output ready);
endinterface

interface km_out_if;
    import km_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CIDX_W-1:0]        cluster_index;
    logic signed [HVAL_W-1:0] head_value;
    logic                     status;

    modport source (output valid, cluster_index, head_value, status, input ready);
    modport sink   (input valid, cluster_index, head_value, status, output ready);
endinterface

`default_nettype wire

// File: design/kmeans_cluster_fit.sv
// Top level of the Lloyd k-means block: controller plus datapath.
// Depends on km_pkg, km_chan_if, km_ctrl and km_dp.
//
//  channel   direction  carries
//  i_in      in         command, row_index, feature_index, element_value
//  o_out     out        cluster_index, head_value, status
//  i_cfg_*   in         register writes (index, data), no read-back
//
// Nearest walks the distance over every used head and feature. One fit round
// assigns every sample, clears the sums, accumulates them and divides once per
// used element of each nonempty head. After reset a clearing pass runs before
// the first item is taken. A held result lets one more item in, which then
// waits for the output register before the input opens again.
`timescale 1ns / 1ps
`default_nettype none

module kmeans_cluster_fit #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_FEATURES = 64,
    parameter int MAX_SAMPLES  = 1024,
    parameter int VALUE_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [km_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [km_pkg::CFG_DATA_W-1:0] i_cfg_data,
    km_in_if.sink                              i_in,
    km_out_if.source                           o_out
);
    import km_pkg::*;

    localparam int CW    = $clog2(MAX_CLUSTERS);
    localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SW    = $clog2(MAX_SAMPLES);
    localparam int SUM_N = MAX_CLUSTERS * MAX_FEATURES;
    localparam int CLW   = $clog2((MAX_SAMPLES > SUM_N) ? MAX_SAMPLES : SUM_N);

    t_dp_cmd                      w_cmd;
    t_dp_sts                      w_sts;
    logic [SW-1:0]                w_i;
    logic [CW-1:0]                w_j;
    logic [FW-1:0]                w_f;
    logic [CLW-1:0]               w_clr;
    logic signed [VALUE_BITS-1:0] w_val;
    logic [CW-1:0]                w_best;
    logic [CW-1:0]                w_asg;
    logic signed [VALUE_BITS-1:0] w_head;

    km_ctrl #(
        .MC (MAX_CLUSTERS),
        .MF (MAX_FEATURES),
        .MS (MAX_SAMPLES),
        .VB (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .o_i         (w_i),
        .o_j         (w_j),
        .o_f         (w_f),
        .o_clr       (w_clr),
        .o_val       (w_val),
        .i_best      (w_best),
        .i_asg       (w_asg),
        .i_head      (w_head)
    );

    km_dp #(
        .MC (MAX_CLUSTERS),
        .MF (MAX_FEATURES),
        .MS (MAX_SAMPLES),
        .VB (VALUE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_i     (w_i),
        .i_j     (w_j),
        .i_f     (w_f),
        .i_clr   (w_clr),
        .i_val   (w_val),
        .o_sts   (w_sts),
        .o_best  (w_best),
        .o_asg   (w_asg),
        .o_head  (w_head)
    );

endmodule

`default_nettype wire

// File: design/km_div.sv
// Restoring divider: signed sum over unsigned member count, truncated
// toward zero, one quotient bit per cycle. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module km_div #(
    parameter int SUW = 27,
    parameter int CNW = 11,
    parameter int VB  = 16,
    localparam int KW = $clog2(SUW + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [SUW-1:0] i_dividend,
    input  wire logic [CNW-1:0]        i_divisor,
    output logic                       o_done,
    output logic signed [VB-1:0]       o_quot
);

    logic [SUW-1:0] r_quo;
    logic [CNW-1:0] r_rem;
    logic [CNW-1:0] r_dvs;
    logic           r_neg;
    logic [KW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [SUW-1:0] w_mag;
    logic [CNW:0]   w_trial;
    logic           w_fit;
    logic [SUW-1:0] w_signed_q;

    // Magnitude of the dividend, one trial subtraction per cycle and the quotient's sign.
    always_comb begin
        w_mag      = i_dividend[SUW-1] ? SUW'(-i_dividend) : SUW'(i_dividend);
        w_trial    = {r_rem, r_quo[SUW-1]};
        w_fit      = (w_trial >= {1'b0, r_dvs});
        w_signed_q = r_neg ? (~r_quo + 1'b1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= KW'(SUW);
            r_quo  <= w_mag;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_neg  <= i_dividend[SUW-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[SUW-2:0], w_fit};
            r_rem <= w_fit ? CNW'(w_trial - {1'b0, r_dvs}) : w_trial[CNW-1:0];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = w_signed_q[VB-1:0];

endmodule

`default_nettype wire

// File: design/km_dp.sv
// Datapath of the k-means block: head, sample, assignment, query and sum
// memories, distance accumulator, best-head tracker and the divider.
// Depends on km_pkg and km_div.
`timescale 1ns / 1ps
`default_nettype none

module km_dp #(
    parameter int MC = 16,
    parameter int MF = 64,
    parameter int MS = 1024,
    parameter int VB = 16,
    localparam int CW    = $clog2(MC),
    localparam int FW    = (MF > 1) ? $clog2(MF) : 1,
    localparam int SW    = $clog2(MS),
    localparam int SUM_N = MC * MF,
    localparam int CLW   = $clog2((MS > SUM_N) ? MS : SUM_N)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire km_pkg::t_dp_cmd         i_cmd,
    input  wire logic [SW-1:0]           i_i,
    input  wire logic [CW-1:0]           i_j,
    input  wire logic [FW-1:0]           i_f,
    input  wire logic [CLW-1:0]          i_clr,
    input  wire logic signed [VB-1:0]    i_val,
    output km_pkg::t_dp_sts              o_sts,
    output logic [CW-1:0]                o_best,
    output logic [CW-1:0]                o_asg,
    output logic signed [VB-1:0]         o_head
);
    import km_pkg::*;

    localparam int HAW = $clog2(SUM_N);
    localparam int SAW = $clog2(MS * MF);
    localparam int SUW = VB + SW + 1;
    localparam int CNW = $clog2(MS + 1);
    localparam int DW  = 2 * VB + FW + 2;

    logic signed [VB-1:0]  r_head_mem  [SUM_N];
    logic signed [VB-1:0]  r_samp_mem  [MS*MF];
    logic [CW-1:0]         r_asg_mem   [MS];
    logic signed [VB-1:0]  r_query_mem [MF];
    logic signed [SUW-1:0] r_sum_mem   [SUM_N];
    logic [CNW-1:0]        r_cnt       [MC];

    logic signed [VB-1:0]  r_head_q;
    logic signed [VB-1:0]  r_samp_q;
    logic signed [VB-1:0]  r_query_q;
    logic [CW-1:0]         r_asg_q;
    logic signed [SUW-1:0] r_sum_q;
    logic [VB:0]           r_ad;
    logic [DW-1:0]         r_acc;
    logic [DW-1:0]         r_best_d;
    logic [CW-1:0]         r_best;

    t_dp_op                w_op;
    logic [CW-1:0]         w_row_h;
    logic [HAW-1:0]        w_head_addr;
    logic [HAW-1:0]        w_sum_addr;
    logic [SAW-1:0]        w_samp_addr;
    logic signed [VB-1:0]  w_a;
    logic signed [VB:0]    w_diff;
    logic [VB:0]           w_absd;
    logic [2*VB+1:0]       w_sq;
    logic [DW-1:0]         w_term;
    logic [CNW-1:0]        w_cnt_q;
    logic                  w_div_done;
    logic signed [VB-1:0]  w_quot;

    // Address selection: accumulation addresses sums by the sample's cluster.
    always_comb begin
        w_op        = i_cmd.op;
        w_row_h     = (w_op == OP_ACC_RD || w_op == OP_ACC_WR) ? r_asg_q : i_j;
        w_head_addr = HAW'(32'(i_j) * MF + 32'(i_f));
        w_sum_addr  = (w_op == OP_SUM_CLR) ? i_clr[HAW-1:0]
                                           : HAW'(32'(w_row_h) * MF + 32'(i_f));
        w_samp_addr = SAW'(32'(i_i) * MF + 32'(i_f));
        w_cnt_q     = r_cnt[w_row_h];
    end

    // Distance term from the registered element pair.
    always_comb begin
        w_a    = i_cmd.use_query ? r_query_q : r_samp_q;
        w_diff = (VB+1)'(w_a) - (VB+1)'(r_head_q);
        w_absd = w_diff[VB] ? (VB+1)'(-w_diff) : (VB+1)'(w_diff);
        w_sq   = r_ad * r_ad;
        w_term = i_cmd.mode ? DW'(r_ad) : DW'(w_sq);
    end

    // Head memory: loads and update results in, element reads out.
    always_ff @(posedge i_clk) begin
        if (w_op == OP_HEAD_LD) begin
            r_head_mem[w_head_addr] <= i_val;
        end else if (w_op == OP_HEAD_WR) begin
            r_head_mem[w_head_addr] <= w_quot;
        end
        if (w_op == OP_HEAD_RD || w_op == OP_DIST_RD) begin
            r_head_q <= r_head_mem[w_head_addr];
        end
    end

    // Sample memory.
    always_ff @(posedge i_clk) begin
        if (w_op == OP_SAMP_LD) begin
            r_samp_mem[w_samp_addr] <= i_val;
        end
        if (w_op == OP_DIST_RD || w_op == OP_ACC_RD) begin
            r_samp_q <= r_samp_mem[w_samp_addr];
        end
    end

    // Query vector, cleared by the pass after reset.
    always_ff @(posedge i_clk) begin
        if (w_op == OP_CLEAR) begin
            if (32'(i_clr) < MF) begin
                r_query_mem[i_clr[FW-1:0]] <= '0;
            end
        end else if (w_op == OP_QUERY_LD) begin
            r_query_mem[i_f] <= i_val;
        end
        if (w_op == OP_DIST_RD) begin
            r_query_q <= r_query_mem[i_f];
        end
    end

    // Assignment memory, cleared by the pass after reset.
    always_ff @(posedge i_clk) begin
        if (w_op == OP_CLEAR) begin
            if (32'(i_clr) < MS) begin
                r_asg_mem[i_clr[SW-1:0]] <= '0;
            end
        end else if (w_op == OP_ASG_WR) begin
            r_asg_mem[i_i] <= r_best;
        end
        if (w_op == OP_ASG_RD) begin
            r_asg_q <= r_asg_mem[i_i];
        end
    end

    // Sum memory: cleared, then read-modify-written per sample element.
    always_ff @(posedge i_clk) begin
        if (w_op == OP_SUM_CLR) begin
            r_sum_mem[w_sum_addr] <= '0;
        end else if (w_op == OP_ACC_WR) begin
            r_sum_mem[w_sum_addr] <= r_sum_q + SUW'(r_samp_q);
        end
        if (w_op == OP_ACC_RD || w_op == OP_SUM_RD) begin
            r_sum_q <= r_sum_mem[w_sum_addr];
        end
    end

    // Member counts per cluster.
    always_ff @(posedge i_clk) begin
        if (w_op == OP_SUM_CLR && i_cmd.first) begin
            for (int k = 0; k < MC; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (w_op == OP_ACC_WR && i_cmd.last) begin
            r_cnt[w_row_h] <= w_cnt_q + 1'b1;
        end
    end

    // Distance accumulation and nearest-head tracking.
    always_ff @(posedge i_clk) begin
        if (w_op == OP_DIST_DF) begin
            r_ad <= w_absd;
        end
        if (w_op == OP_DIST_AC) begin
            r_acc <= i_cmd.first ? w_term : r_acc + w_term;
        end
        if (w_op == OP_DIST_CMP && (i_cmd.first || r_acc < r_best_d)) begin
            r_best_d <= r_acc;
            r_best   <= i_j;
        end
    end

    km_div #(
        .SUW (SUW),
        .CNW (CNW),
        .VB  (VB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_op == OP_DIV_START),
        .i_dividend (r_sum_q),
        .i_divisor  (w_cnt_q),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_sts.div_done = w_div_done;
    assign o_sts.cnt_zero = (w_cnt_q == '0);
    assign o_best         = r_best;
    assign o_asg          = r_asg_q;
    assign o_head         = r_head_q;

endmodule

`default_nettype wire

// File: design/km_ctrl.sv
// Controller of the k-means block: configuration registers, item handshake,
// output register and the sequencer that walks samples, heads and features.
// Depends on km_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module km_ctrl #(
    parameter int MC = 16,
    parameter int MF = 64,
    parameter int MS = 1024,
    parameter int VB = 16,
    localparam int CW    = $clog2(MC),
    localparam int FW    = (MF > 1) ? $clog2(MF) : 1,
    localparam int SW    = $clog2(MS),
    localparam int SUM_N = MC * MF,
    localparam int CLW   = $clog2((MS > SUM_N) ? MS : SUM_N)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [km_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [km_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    km_in_if.sink                                 i_in,
    km_out_if.source                              o_out,
    output km_pkg::t_dp_cmd                       o_cmd,
    input  wire km_pkg::t_dp_sts                  i_sts,
    output logic [SW-1:0]                         o_i,
    output logic [CW-1:0]                         o_j,
    output logic [FW-1:0]                         o_f,
    output logic [CLW-1:0]                        o_clr,
    output logic signed [VB-1:0]                  o_val,
    input  wire logic [CW-1:0]                    i_best,
    input  wire logic [CW-1:0]                    i_asg,
    input  wire logic signed [VB-1:0]             i_head
);
    import km_pkg::*;

    localparam int NCW   = $clog2(MC + 1);
    localparam int NFW   = $clog2(MF + 1);
    localparam int NSW   = $clog2(MS + 1);
    localparam int CLR_N = (MS > MF) ? MS : MF;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_RD, S_FIN, S_FIT,
        S_DRD, S_DDF, S_DAC, S_DCMP, S_AS_WR, S_SCLR,
        S_AC_ARD, S_AC_RD, S_AC_WR,
        S_UP_J, S_UP_RD, S_UP_DS, S_UP_DV, S_UP_WR, S_IT_END
    } t_state;

    t_state                   r_state;
    logic [CLU_W-1:0]         r_clusters;
    logic [FCNT_W-1:0]        r_features;
    logic [SCNT_W-1:0]        r_samples;
    logic [ITER_W-1:0]        r_iters;
    logic                     r_mode;
    t_cmd                     r_cmd;
    logic [ROW_W-1:0]         r_row;
    logic [FEAT_W-1:0]        r_fi;
    logic signed [ELEM_W-1:0] r_val;
    logic                     r_bad;
    logic [SW-1:0]            r_i;
    logic [CW-1:0]            r_j;
    logic [FW-1:0]            r_f;
    logic [CLW-1:0]           r_clr;
    logic [ITER_W-1:0]        r_it;
    logic                     r_ov;
    logic [CIDX_W-1:0]        r_ocidx;
    logic signed [HVAL_W-1:0] r_ohval;
    logic                     r_ostat;

    logic [NCW-1:0] w_nc;
    logic [NFW-1:0] w_nf;
    logic [NSW-1:0] w_ns;
    logic           w_i_last;
    logic           w_j_last;
    logic           w_f_last;
    logic           w_bad;

    // Counts saturated to their usable ranges, and walk end flags.
    always_comb begin
        w_nc = (r_clusters == '0) ? NCW'(1)
             : ((32'(r_clusters) > MC) ? NCW'(MC) : NCW'(r_clusters));
        w_nf = (r_features == '0) ? NFW'(1)
             : ((32'(r_features) > MF) ? NFW'(MF) : NFW'(r_features));
        w_ns = (r_samples == '0) ? NSW'(1)
             : ((32'(r_samples) > MS) ? NSW'(MS) : NSW'(r_samples));
        w_i_last = (r_i == SW'(w_ns - 1'b1));
        w_j_last = (r_j == CW'(w_nc - 1'b1));
        w_f_last = (r_f == FW'(w_nf - 1'b1));
    end

    // Index checks of the latched item.
    always_comb begin
        case (r_cmd) inside
            CMD_LD_HEAD, CMD_RD_HEAD:
                w_bad = !((32'(r_row) < 32'(w_nc)) && (32'(r_fi) < 32'(w_nf)));
            CMD_LD_SAMPLE:
                w_bad = !((32'(r_row) < 32'(w_ns)) && (32'(r_fi) < 32'(w_nf)));
            CMD_LD_QUERY:
                w_bad = !(32'(r_fi) < 32'(w_nf));
            CMD_RD_ASG:
                w_bad = !(32'(r_row) < 32'(w_ns));
            CMD_FIT, CMD_NEAREST:
                w_bad = 1'b0;
            default:
                w_bad = 1'b1;
        endcase
    end

    // Datapath operation for the current state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = OP_NONE;
        o_cmd.use_query = (r_cmd == CMD_NEAREST);
        o_cmd.mode      = r_mode;
        unique case (r_state)
            S_CLEAR: o_cmd.op = OP_CLEAR;
            S_EXEC: begin
                if (!w_bad) begin
                    case (r_cmd)
                        CMD_LD_HEAD:   o_cmd.op = OP_HEAD_LD;
                        CMD_LD_SAMPLE: o_cmd.op = OP_SAMP_LD;
                        CMD_LD_QUERY:  o_cmd.op = OP_QUERY_LD;
                        CMD_RD_ASG:    o_cmd.op = OP_ASG_RD;
                        CMD_RD_HEAD:   o_cmd.op = OP_HEAD_RD;
                        default:       o_cmd.op = OP_NONE;
                    endcase
                end
            end
            S_DRD:  o_cmd.op = OP_DIST_RD;
            S_DDF:  o_cmd.op = OP_DIST_DF;
            S_DAC: begin
                o_cmd.op    = OP_DIST_AC;
                o_cmd.first = (r_f == '0);
            end
            S_DCMP: begin
                o_cmd.op    = OP_DIST_CMP;
                o_cmd.first = (r_j == '0);
            end
            S_AS_WR: o_cmd.op = OP_ASG_WR;
            S_SCLR: begin
                o_cmd.op    = OP_SUM_CLR;
                o_cmd.first = (r_clr == '0);
            end
            S_AC_ARD: o_cmd.op = OP_ASG_RD;
            S_AC_RD:  o_cmd.op = OP_ACC_RD;
            S_AC_WR: begin
                o_cmd.op   = OP_ACC_WR;
                o_cmd.last = w_f_last;
            end
            S_UP_RD: o_cmd.op = OP_SUM_RD;
            S_UP_DS: o_cmd.op = OP_DIV_START;
            S_UP_WR: o_cmd.op = OP_HEAD_WR;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    // State, counters, configuration and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_ov       <= 1'b0;
            r_clusters <= CLU_W'(16);
            r_features <= FCNT_W'(64);
            r_samples  <= SCNT_W'(1024);
            r_iters    <= ITER_W'(10);
            r_mode     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_index))
                    REG_CLUSTERS: r_clusters <= i_cfg_data[CLU_W-1:0];
                    REG_FEATURES: r_features <= i_cfg_data[FCNT_W-1:0];
                    REG_SAMPLES:  r_samples  <= i_cfg_data[SCNT_W-1:0];
                    REG_ITERS:    r_iters    <= i_cfg_data[ITER_W-1:0];
                    REG_MODE:     r_mode     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // The finishing state refills the output register itself.
            if (r_ov && o_out.ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == CLW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd   <= t_cmd'(i_in.command);
                        r_row   <= i_in.row_index;
                        r_fi    <= i_in.feature_index;
                        r_val   <= i_in.element_value;
                        r_i     <= SW'(i_in.row_index);
                        r_j     <= CW'(i_in.row_index);
                        r_f     <= FW'(i_in.feature_index);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_bad <= w_bad;
                    case (r_cmd)
                        CMD_FIT: r_state <= S_FIT;
                        CMD_NEAREST: begin
                            r_j     <= '0;
                            r_f     <= '0;
                            r_state <= S_DRD;
                        end
                        CMD_RD_ASG, CMD_RD_HEAD: r_state <= w_bad ? S_FIN : S_RD;
                        default: r_state <= S_FIN;
                    endcase
                end
                S_RD: r_state <= S_FIN;
                S_FIT: begin
                    r_it <= '0;
                    r_i  <= '0;
                    r_j  <= '0;
                    r_f  <= '0;
                    r_state <= (r_iters == '0) ? S_FIN : S_DRD;
                end
                S_DRD: r_state <= S_DDF;
                S_DDF: r_state <= S_DAC;
                S_DAC: begin
                    if (w_f_last) begin
                        r_state <= S_DCMP;
                    end else begin
                        r_f     <= r_f + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_DCMP: begin
                    r_f <= '0;
                    if (w_j_last) begin
                        r_state <= (r_cmd == CMD_NEAREST) ? S_FIN : S_AS_WR;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_AS_WR: begin
                    r_j <= '0;
                    if (w_i_last) begin
                        r_clr   <= '0;
                        r_state <= S_SCLR;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_SCLR: begin
                    if (r_clr == CLW'(SUM_N - 1)) begin
                        r_i     <= '0;
                        r_state <= S_AC_ARD;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_AC_ARD: begin
                    r_f     <= '0;
                    r_state <= S_AC_RD;
                end
                S_AC_RD: r_state <= S_AC_WR;
                S_AC_WR: begin
                    if (w_f_last) begin
                        if (w_i_last) begin
                            r_j     <= '0;
                            r_state <= S_UP_J;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_AC_ARD;
                        end
                    end else begin
                        r_f     <= r_f + 1'b1;
                        r_state <= S_AC_RD;
                    end
                end
                S_UP_J: begin
                    r_f <= '0;
                    if (!i_sts.cnt_zero) begin
                        r_state <= S_UP_RD;
                    end else if (w_j_last) begin
                        r_state <= S_IT_END;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_UP_RD: r_state <= S_UP_DS;
                S_UP_DS: r_state <= S_UP_DV;
                S_UP_DV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    if (w_f_last) begin
                        if (w_j_last) begin
                            r_state <= S_IT_END;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_UP_J;
                        end
                    end else begin
                        r_f     <= r_f + 1'b1;
                        r_state <= S_UP_RD;
                    end
                end
                S_IT_END: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_f <= '0;
                    if (r_it == r_iters - 1'b1) begin
                        r_state <= S_FIN;
                    end else begin
                        r_it    <= r_it + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_FIN: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_ostat <= r_bad;
                        r_ocidx <= (r_cmd == CMD_NEAREST) ? CIDX_W'(i_best)
                                 : ((r_cmd == CMD_RD_ASG && !r_bad) ? CIDX_W'(i_asg) : '0);
                        r_ohval <= (r_cmd == CMD_RD_HEAD && !r_bad) ? HVAL_W'(i_head) : '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.cluster_index = r_ocidx;
    assign o_out.head_value    = r_ohval;
    assign o_out.status        = r_ostat;
    assign o_i                 = r_i;
    assign o_j                 = r_j;
    assign o_f                 = r_f;
    assign o_clr               = r_clr;
    assign o_val               = VB'(r_val);

endmodule

`default_nettype wire

// File: design/km_check.sv
// Port-level checks for the k-means block, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module km_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  i_out_cidx,
    input wire logic [15:0] i_out_hval,
    input wire logic        i_out_status
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_cidx) && $stable(i_out_hval)
            && $stable(i_out_status))
        else $error("stalled result changed");

    // One item at a time: ready drops right after an accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while another is in work");

    // A rejected item carries zero fields.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> i_out_cidx == 4'd0 && i_out_hval == 16'd0)
        else $error("rejected item with nonzero fields");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind kmeans_cluster_fit km_check u_km_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_cidx   (o_out.cluster_index),
    .i_out_hval   (o_out.head_value),
    .i_out_status (o_out.status)
);

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the k-means fitting block kmeans_cluster_fit.
// Depends on km_pkg and the channel interfaces in km_chan_if; a built-in
// predictor tracks heads, samples, assignments and the query vector.
`timescale 1ns / 1ps

module tb;
    import km_pkg::*;

    localparam int NUM_HEADS   = 16;
    localparam int NUM_FEAT    = 64;
    localparam int NUM_SAMPLES = 1024;
    localparam int STALL_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [CIDX_W-1:0]        cidx;
        logic signed [HVAL_W-1:0] hval;
        logic                     status;
    } t_km_result;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        int               row;
        int               fi;
        int               val;
        bit               typed;
        t_km_result       res;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    km_in_if  in_ch ();
    km_out_if out_ch ();

    kmeans_cluster_fit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predicted block state and register copies.
    logic signed [ELEM_W-1:0] head_m   [NUM_HEADS][NUM_FEAT];
    logic signed [ELEM_W-1:0] sample_m [NUM_SAMPLES][NUM_FEAT];
    logic signed [ELEM_W-1:0] query_m  [NUM_FEAT];
    logic [CIDX_W-1:0]        assign_m [NUM_SAMPLES];
    logic [CLU_W-1:0]         reg_clusters;
    logic [FCNT_W-1:0]        reg_features;
    logic [SCNT_W-1:0]        reg_samples;
    logic [ITER_W-1:0]        reg_iters;
    logic                     reg_mode;

    t_km_result pending_results[$];
    t_stim_row  directed_rows[$];
    int         mismatch_count;
    int         idle_cycles;
    bit         quiet;
    bit         hold_req;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_count(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Distance from the query (or a sample row) to one head.
    function automatic longint unsigned head_distance(bit from_query, int srow, int h, int nf);
        longint unsigned acc;
        longint          d;
        acc = 0;
        for (int f = 0; f < nf; f++) begin
            d = from_query ? longint'(query_m[f]) : longint'(sample_m[srow][f]);
            d = d - longint'(head_m[h][f]);
            if (d < 0) d = -d;
            acc += reg_mode ? longint'(d) : longint'(d * d);
        end
        return acc;
    endfunction

    // Lowest-index head at the smallest distance.
    function automatic int closest_head(bit from_query, int srow, int nc, int nf);
        int              best;
        longint unsigned best_d;
        longint unsigned d;
        best = 0;
        best_d = head_distance(from_query, srow, 0, nf);
        for (int j = 1; j < nc; j++) begin
            d = head_distance(from_query, srow, j, nf);
            if (d < best_d) begin
                best_d = d;
                best = j;
            end
        end
        return best;
    endfunction

    // Lloyd rounds: assign all samples, then move nonempty heads to their means.
    task automatic run_lloyd();
        int     nc;
        int     nf;
        int     ns;
        longint sums [NUM_HEADS][NUM_FEAT];
        int     members [NUM_HEADS];
        nc = clamp_count(reg_clusters, NUM_HEADS);
        nf = clamp_count(reg_features, NUM_FEAT);
        ns = clamp_count(reg_samples, NUM_SAMPLES);
        for (int it = 0; it < reg_iters; it++) begin
            for (int i = 0; i < ns; i++)
                assign_m[i] = CIDX_W'(closest_head(1'b0, i, nc, nf));
            for (int j = 0; j < NUM_HEADS; j++) begin
                members[j] = 0;
                for (int f = 0; f < NUM_FEAT; f++) sums[j][f] = 0;
            end
            for (int i = 0; i < ns; i++) begin
                for (int f = 0; f < nf; f++) sums[assign_m[i]][f] += sample_m[i][f];
                members[assign_m[i]]++;
            end
            for (int j = 0; j < nc; j++) begin
                if (members[j] != 0) begin
                    for (int f = 0; f < nf; f++)
                        head_m[j][f] = ELEM_W'(sums[j][f] / members[j]);
                end
            end
        end
    endtask

    // Apply one item to the predicted state and return its result.
    task automatic apply_item(input logic [CMD_W-1:0] cmd, input int row, input int fi,
                              input int val, output t_km_result res);
        int nc;
        int nf;
        int ns;
        bit fok;
        nc = clamp_count(reg_clusters, NUM_HEADS);
        nf = clamp_count(reg_features, NUM_FEAT);
        ns = clamp_count(reg_samples, NUM_SAMPLES);
        fok = fi < nf;
        res = '0;
        case (cmd)
            CMD_LD_HEAD: begin
                if (row < nc && fok) head_m[row][fi] = ELEM_W'(val);
                else res.status = 1'b1;
            end
            CMD_LD_SAMPLE: begin
                if (row < ns && fok) sample_m[row][fi] = ELEM_W'(val);
                else res.status = 1'b1;
            end
            CMD_FIT: run_lloyd();
            CMD_LD_QUERY: begin
                if (fok) query_m[fi] = ELEM_W'(val);
                else res.status = 1'b1;
            end
            CMD_NEAREST: res.cidx = CIDX_W'(closest_head(1'b1, 0, nc, nf));
            CMD_RD_ASG: begin
                if (row < ns) res.cidx = assign_m[row];
                else res.status = 1'b1;
            end
            CMD_RD_HEAD: begin
                if (row < nc && fok) res.hval = head_m[row][fi];
                else res.status = 1'b1;
            end
            default: res.status = 1'b1;
        endcase
    endtask

    // Offer one item, wait for it to be taken, then record its expected result.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int row, input int fi,
                             input int val, input bit typed, input t_km_result typed_res);
        t_km_result res;
        while (!quiet && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.row_index     <= row[ROW_W-1:0];
        in_ch.feature_index <= fi[FEAT_W-1:0];
        in_ch.element_value <= val[ELEM_W-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        apply_item(cmd, row, fi, val, res);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
    endtask

    task automatic send_plain(input logic [CMD_W-1:0] cmd, input int row, input int fi,
                              input int val);
        send_item(cmd, row, fi, val, 1'b0, '0);
    endtask

    // Wait for the block to drain, then write all five registers.
    task automatic set_registers(input int nc, input int nf, input int ns, input int iters,
                                 input int mode);
        int vals [5];
        vals = '{nc, nf, ns, iters, mode};
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int r = REG_CLUSTERS; r <= REG_MODE; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r[CFG_IDX_W-1:0];
            i_cfg_data  <= vals[r][CFG_DATA_W-1:0];
            @(posedge i_clk);
        end
        i_cfg_we     <= 1'b0;
        reg_clusters = nc[CLU_W-1:0];
        reg_features = nf[FCNT_W-1:0];
        reg_samples  = ns[SCNT_W-1:0];
        reg_iters    = iters[ITER_W-1:0];
        reg_mode     = mode[0];
    endtask

    // Elements mostly gather around a few centers; some span the full range.
    function automatic int pick_element();
        int centers [3];
        centers = '{-2000, 0, 3000};
        if ($urandom_range(3) == 0) return int'(shortint'($urandom_range(65535)));
        return centers[$urandom_range(2)] + int'($urandom_range(600)) - 300;
    endfunction

    // Load every head, sample and query element in use, then a random mix.
    // With hold set, the receiver holds off as the loads begin.
    task automatic run_phase(input int nc_raw, input int nf_raw, input int ns_raw,
                             input int iters, input int mode, input int mix_items,
                             input int fit_budget, input bit hold);
        int nc;
        int nf;
        int ns;
        int pick;
        int fits_left;
        set_registers(nc_raw, nf_raw, ns_raw, iters, mode);
        hold_req = hold;
        nc = clamp_count(nc_raw, NUM_HEADS);
        nf = clamp_count(nf_raw, NUM_FEAT);
        ns = clamp_count(ns_raw, NUM_SAMPLES);
        fits_left = fit_budget;
        for (int h = 0; h < nc; h++)
            for (int f = 0; f < nf; f++) send_plain(CMD_LD_HEAD, h, f, pick_element());
        for (int s = 0; s < ns; s++)
            for (int f = 0; f < nf; f++) send_plain(CMD_LD_SAMPLE, s, f, pick_element());
        for (int f = 0; f < nf; f++) send_plain(CMD_LD_QUERY, $urandom_range(1023), f,
                                                pick_element());
        for (int n = 0; n < mix_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 12)
                send_plain(CMD_LD_HEAD, $urandom_range(nc - 1), $urandom_range(nf - 1),
                           pick_element());
            else if (pick < 24)
                send_plain(CMD_LD_SAMPLE, $urandom_range(ns - 1), $urandom_range(nf - 1),
                           pick_element());
            else if (pick < 32)
                send_plain(CMD_LD_QUERY, $urandom_range(1023), $urandom_range(nf - 1),
                           pick_element());
            else if (pick < 48)
                send_plain(CMD_NEAREST, $urandom_range(1023), $urandom_range(63),
                           $urandom_range(65535));
            else if (pick < 64)
                send_plain(CMD_RD_ASG, $urandom_range(1) ? $urandom_range(ns - 1)
                           : $urandom_range(1023), $urandom_range(63), $urandom_range(65535));
            else if (pick < 78)
                send_plain(CMD_RD_HEAD, $urandom_range(nc - 1), $urandom_range(nf - 1),
                           $urandom_range(65535));
            else if (pick < 84 && fits_left > 0) begin
                fits_left--;
                send_plain(CMD_FIT, $urandom_range(1023), $urandom_range(63),
                           $urandom_range(65535));
            end else if (pick < 88)
                send_plain(CMD_LD_HEAD, $urandom_range(1023, nc), $urandom_range(63),
                           $urandom_range(65535));
            else if (pick < 91)
                send_plain(CMD_LD_SAMPLE, $urandom_range(1023, ns), $urandom_range(63),
                           $urandom_range(65535));
            else if (pick < 94 && nf < NUM_FEAT)
                send_plain(CMD_LD_QUERY, $urandom_range(1023), $urandom_range(63, nf),
                           $urandom_range(65535));
            else if (pick < 97)
                send_plain(CMD_RD_HEAD, $urandom_range(1023, nc), $urandom_range(63),
                           $urandom_range(65535));
            else
                send_plain(CMD_UNKNOWN, $urandom_range(1023), $urandom_range(63),
                           $urandom_range(65535));
        end
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input int row, input int fi,
                           input int val, input bit typed, input int cidx, input int hval,
                           input int status);
        t_stim_row r;
        r.cmd = cmd;
        r.row = row;
        r.fi = fi;
        r.val = val;
        r.typed = typed;
        r.res.cidx = cidx[CIDX_W-1:0];
        r.res.hval = hval[HVAL_W-1:0];
        r.res.status = status[0];
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (hold_req) begin
            out_ch.ready <= 1'b0;
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
        end else begin
            out_ch.ready <= quiet || ($urandom_range(99) >= 19);
        end
    end

    // Result checker against the oldest pending expectation.
    always @(posedge i_clk) begin
        t_km_result want;
        if (out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: cidx=%0d hval=%0d status=%0d",
                             out_ch.cluster_index, out_ch.head_value, out_ch.status);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.cluster_index !== want.cidx || out_ch.head_value !== want.hval
                    || out_ch.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected cidx=%0d hval=%0d status=%0d, %s",
                                 want.cidx, want.hval, want.status,
                                 $sformatf("got cidx=%0d hval=%0d status=%0d",
                                           out_ch.cluster_index, out_ch.head_value,
                                           out_ch.status));
                end
            end
        end
    end

    // Watchdog on cycles without any item moving.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.command       = '0;
        in_ch.row_index     = '0;
        in_ch.feature_index = '0;
        in_ch.element_value = '0;
        out_ch.ready        = 1'b0;
        mismatch_count      = 0;
        idle_cycles         = 0;
        quiet               = 1'b0;
        hold_req            = 1'b0;
        reg_clusters        = 16;
        reg_features        = 64;
        reg_samples         = 1024;
        reg_iters           = 10;
        reg_mode            = 1'b0;
        for (int i = 0; i < NUM_SAMPLES; i++) assign_m[i] = '0;
        for (int f = 0; f < NUM_FEAT; f++) query_m[f] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: two heads, two features, two samples, zero rounds.
        set_registers(2, 2, 2, 0, 0);
        add_row(CMD_RD_ASG, 0, 0, 0, 1, 0, 0, 0);
        add_row(CMD_RD_ASG, 1023, 63, 0, 1, 0, 0, 1);
        add_row(CMD_LD_HEAD, 0, 0, 32767, 1, 0, 0, 0);
        add_row(CMD_LD_HEAD, 0, 1, -32768, 1, 0, 0, 0);
        add_row(CMD_LD_HEAD, 1, 0, 0, 1, 0, 0, 0);
        add_row(CMD_LD_HEAD, 1, 1, -1, 1, 0, 0, 0);
        add_row(CMD_LD_HEAD, 2, 0, 5, 1, 0, 0, 1);
        add_row(CMD_LD_HEAD, 0, 63, 5, 1, 0, 0, 1);
        add_row(CMD_RD_HEAD, 0, 0, 0, 1, 0, 32767, 0);
        add_row(CMD_RD_HEAD, 0, 1, 0, 1, 0, -32768, 0);
        add_row(CMD_RD_HEAD, 1023, 0, 0, 1, 0, 0, 1);
        add_row(CMD_LD_SAMPLE, 0, 0, -32768, 1, 0, 0, 0);
        add_row(CMD_LD_SAMPLE, 0, 1, 32767, 1, 0, 0, 0);
        add_row(CMD_LD_SAMPLE, 1, 0, 100, 1, 0, 0, 0);
        add_row(CMD_LD_SAMPLE, 1, 1, -100, 1, 0, 0, 0);
        add_row(CMD_LD_SAMPLE, 2, 0, 1, 1, 0, 0, 1);
        add_row(CMD_LD_QUERY, 1023, 1, 300, 1, 0, 0, 0);
        add_row(CMD_LD_QUERY, 0, 2, 300, 1, 0, 0, 1);
        add_row(CMD_FIT, 0, 0, 0, 1, 0, 0, 0);
        add_row(CMD_RD_ASG, 1, 0, 0, 1, 0, 0, 0);
        add_row(CMD_NEAREST, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_UNKNOWN, 1023, 63, -1, 1, 0, 0, 1);
        foreach (directed_rows[k])
            send_item(directed_rows[k].cmd, directed_rows[k].row, directed_rows[k].fi,
                      directed_rows[k].val, directed_rows[k].typed, directed_rows[k].res);

        // Random part over several register settings, saturated ones included.
        run_phase(0, 0, 0, 255, 1, 80, 1, 1'b0);
        quiet = 1'b1;
        run_phase(3, 5, 12, 3, 0, 300, 4, 1'b1);
        quiet = 1'b0;
        run_phase(31, 3, 40, 2, 1, 150, 3, 1'b0);
        run_phase(2, 127, 3, 1, 0, 200, 3, 1'b0);
        run_phase(5, 4, 30, 4, 1, 120, 4, 1'b0);

        // Drain and finish.
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
